/* sv/rbph_pkg.sv */
// ----------------------------------------------------------------------------
// rbph_pkg
// Shared constants for the bounded plane hit pipeline.
// ----------------------------------------------------------------------------
package rbph_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int VEC_W      = 16;
	localparam int EPS_W      = 20;
	localparam int Q_W        = 32;
	localparam int D1_W       = 34;
	localparam int DEN_W      = 33;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 3'd4;

	localparam logic [EPS_W-1:0] EPS_RESET = 20'd2684;

endpackage

/* sv/rbph_div.sv */
// ----------------------------------------------------------------------------
// rbph_div
// Restoring divider, one quotient bit per pipeline stage, with sideband.
// ----------------------------------------------------------------------------
module rbph_div #(
	parameter int SB_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [rbph_pkg::DEN_W-1:0] den,
	input  logic [rbph_pkg::DEN_W-1:0] rem,
	input  logic [rbph_pkg::Q_W-1:0]   num_lo,
	input  logic [SB_W-1:0]           sb,
	output logic                      out_valid,
	output logic [rbph_pkg::Q_W-1:0]   quot,
	output logic [SB_W-1:0]           out_sb
);
	import rbph_pkg::*;

	logic             v_s   [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [DEN_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]   lo_s  [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic [SB_W-1:0]  sb_s  [0:Q_W];

	assign v_s[0]   = in_valid;
	assign den_s[0] = den;
	assign rem_s[0] = rem;
	assign lo_s[0]  = num_lo;
	assign q_s[0]   = '0;
	assign sb_s[0]  = sb;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;
		assign trial = {rem_s[k], lo_s[k][Q_W-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DEN_W'(trial - {1'b0, den_s[k]}) : trial[DEN_W-1:0];
				lo_s[k+1]  <= {lo_s[k][Q_W-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][Q_W-2:0], ge};
				den_s[k+1] <= den_s[k];
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign quot      = q_s[Q_W];
	assign out_sb    = sb_s[Q_W];

endmodule

/* sv/ray_box_bounded_plane_hit.sv */
// Pipeline: 3 setup stages, 32 divider stages of one quotient bit each, then the
// hit point and box compare stages.
// Throughput: one request per cycle while the output is not stalled.
// A stall on a valid output freezes the whole pipeline.
// Reset clears all valid bits and loads the configuration registers with defaults.
// ----------------------------------------------------------------------------
// ray_box_bounded_plane_hit
// Ray against a plane bounded by an axis-aligned box, fixed point, pipelined.
// ----------------------------------------------------------------------------
module ray_box_bounded_plane_hit #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbph_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbph_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic signed [COORD_BITS-1:0]    start_x,
	input  logic signed [COORD_BITS-1:0]    start_y,
	input  logic signed [COORD_BITS-1:0]    start_z,
	input  logic signed [rbph_pkg::VEC_W-1:0] dir_x,
	input  logic signed [rbph_pkg::VEC_W-1:0] dir_y,
	input  logic signed [rbph_pkg::VEC_W-1:0] dir_z,
	input  logic [rbph_pkg::Q_W-1:0]        best_distance,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic                            updated,
	output logic [rbph_pkg::Q_W-1:0]        distance_out
);
	import rbph_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int NS_W   = CB + VEC_W;
	localparam int D2_W   = CB + 18;
	localparam int DIST_W = CB + 19;
	localparam int PR_W   = Q_W + VEC_W + 1;
	localparam int P_W    = ((CB + 22) > PR_W ? CB + 22 : PR_W) + 2;
	localparam int SB_W   = 3 + 3 * CB + 3 * VEC_W + Q_W;

	// configuration
	logic [47:0]      normal_q, center_q, half_q;
	logic [15:0]      offset_q;
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q <= '0;
			offset_q <= '0;
			center_q <= '0;
			half_q   <= '0;
			eps_q    <= EPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NORMAL:    normal_q <= cfg_data;
				REG_OFFSET:    offset_q <= cfg_data[15:0];
				REG_CENTER:    center_q <= cfg_data;
				REG_HALF_SIZE: half_q   <= cfg_data;
				REG_EPSILON:   eps_q    <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [VEC_W-1:0] nrm [0:2];
	assign nrm[0] = $signed(normal_q[15:0]);
	assign nrm[1] = $signed(normal_q[31:16]);
	assign nrm[2] = $signed(normal_q[47:32]);

	// offset taken at coordinate width
	logic [CB+15:0]        off_ext;
	logic signed [CB-1:0]  off_c;
	assign off_ext = {{CB{1'b0}}, offset_q};
	assign off_c   = $signed(off_ext[CB-1:0]);

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: products
	logic                     v_s1, mode_s1;
	logic signed [CB-1:0]     s_s1 [0:2];
	logic signed [VEC_W-1:0]  d_s1 [0:2];
	logic [Q_W-1:0]           best_s1;
	logic signed [2*VEC_W-1:0] nd_s1 [0:2];
	logic signed [NS_W-1:0]   ns_s1 [0:2];
	logic signed [CB-1:0]     s_in [0:2];
	logic signed [VEC_W-1:0]  d_in [0:2];

	assign s_in[0] = start_x;
	assign s_in[1] = start_y;
	assign s_in[2] = start_z;
	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			best_s1 <= best_distance;
			for (int i = 0; i < 3; i++) begin
				s_s1[i]  <= s_in[i];
				d_s1[i]  <= d_in[i];
				nd_s1[i] <= nrm[i] * d_in[i];
				ns_s1[i] <= NS_W'(nrm[i]) * NS_W'(s_in[i]);
			end
		end
	end

	// stage 2: dot products and plane distance
	logic                     v_s2, mode_s2;
	logic signed [CB-1:0]     s_s2 [0:2];
	logic signed [VEC_W-1:0]  d_s2 [0:2];
	logic [Q_W-1:0]           best_s2;
	logic signed [D1_W-1:0]   d1_s2;
	logic signed [DIST_W-1:0] dist_s2;
	logic signed [D2_W-1:0]   d2_c;

	assign d2_c = D2_W'(ns_s1[0]) + D2_W'(ns_s1[1]) + D2_W'(ns_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			best_s2 <= best_s1;
			s_s2    <= s_s1;
			d_s2    <= d_s1;
			d1_s2   <= D1_W'(nd_s1[0]) + D1_W'(nd_s1[1]) + D1_W'(nd_s1[2]);
			dist_s2 <= DIST_W'(d2_c) - (DIST_W'(off_c) <<< 14);
		end
	end

	// stage 3: facing test, divider setup
	logic signed [D1_W-1:0] eps_s, neg_d1;
	logic                   rej_c, sat_c;
	logic [63:0]            num_c;
	logic [DEN_W-1:0]       den_c;

	assign eps_s  = $signed(D1_W'(eps_q));
	assign neg_d1 = -d1_s2;
	assign den_c  = neg_d1[DEN_W-1:0];
	assign rej_c  = (d1_s2 > -eps_s) || (d1_s2 == '0) || dist_s2[DIST_W-1];
	assign num_c  = {{(64-DIST_W){1'b0}}, dist_s2} << 22;
	assign sat_c  = {1'b0, num_c[63:32]} >= den_c;

	logic             v_s3;
	logic [DEN_W-1:0] den_s3, rem_s3;
	logic [Q_W-1:0]   lo_s3;
	logic [SB_W-1:0]  sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= den_c;
			rem_s3 <= sat_c ? '0 : {1'b0, num_c[63:32]};
			lo_s3  <= num_c[31:0];
			sb_s3  <= {mode_s2, rej_c, sat_c, s_s2[0], s_s2[1], s_s2[2],
				d_s2[0], d_s2[1], d_s2[2], best_s2};
		end
	end

	logic            v_dv;
	logic [Q_W-1:0]  quot_dv;
	logic [SB_W-1:0] sb_dv;

	rbph_div #(.SB_W(SB_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.den       (den_s3),
		.rem       (rem_s3),
		.num_lo    (lo_s3),
		.sb        (sb_s3),
		.out_valid (v_dv),
		.quot      (quot_dv),
		.out_sb    (sb_dv)
	);

	logic                    mode_dv, rej_dv, sat_dv;
	logic signed [CB-1:0]    s_dv [0:2];
	logic signed [VEC_W-1:0] d_dv [0:2];
	logic [Q_W-1:0]          best_dv, t_dv;

	assign {mode_dv, rej_dv, sat_dv, s_dv[0], s_dv[1], s_dv[2],
		d_dv[0], d_dv[1], d_dv[2], best_dv} = sb_dv;
	assign t_dv = sat_dv ? '1 : quot_dv;

	// stage 4: t * dir
	logic                    v_s4, mode_s4, rej_s4;
	logic signed [CB-1:0]    s_s4 [0:2];
	logic signed [PR_W-1:0]  pr_s4 [0:2];
	logic [Q_W-1:0]          best_s4, t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4 <= mode_dv;
			rej_s4  <= rej_dv;
			best_s4 <= best_dv;
			t_s4    <= t_dv;
			s_s4    <= s_dv;
			for (int i = 0; i < 3; i++)
				pr_s4[i] <= $signed({1'b0, t_dv}) * PR_W'(d_dv[i]);
		end
	end

	// stage 5: box compare and result
	logic signed [P_W-1:0] p_c  [0:2];
	logic signed [P_W-1:0] lo_c [0:2];
	logic signed [P_W-1:0] hi_c [0:2];
	logic                  inside_c;

	always_comb begin
		inside_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			p_c[i]  = (P_W'(s_s4[i]) <<< 22) + P_W'(pr_s4[i]);
			lo_c[i] = (P_W'($signed(center_q[16*i +: 16])) -
				P_W'($signed(half_q[16*i +: 16]))) <<< 22;
			hi_c[i] = (P_W'($signed(center_q[16*i +: 16])) +
				P_W'($signed(half_q[16*i +: 16]))) <<< 22;
			if (p_c[i] < lo_c[i] || p_c[i] > hi_c[i])
				inside_c = 1'b0;
		end
	end

	logic           v_s5, mode_s5, rej_s5, hit_s5, upd_s5;
	logic [Q_W-1:0] dist_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5 <= mode_s4;
			rej_s5  <= rej_s4;
			hit_s5  <= 1'b0;
			upd_s5  <= 1'b0;
			dist_s5 <= best_s4;
			if (!rej_s4) begin
				if (!mode_s4) begin
					if (inside_c) begin
						hit_s5  <= 1'b1;
						upd_s5  <= 1'b1;
						dist_s5 <= t_s4;
					end
				end else begin
					hit_s5 <= 1'b1;
					if (best_s4 > t_s4 && inside_c) begin
						upd_s5  <= 1'b1;
						dist_s5 <= t_s4;
					end
				end
			end
		end
	end

	assign out_valid    = v_s5;
	assign hit          = hit_s5;
	assign updated      = upd_s5;
	assign distance_out = dist_s5;

`ifndef SYNTHESIS
	a_upd_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && updated |-> hit)
		else $error("update without hit");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rej_s5 |-> !hit && !updated)
		else $error("rejected ray reported a hit");
	a_plane_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mode_s5 |-> hit == updated)
		else $error("plane mode hit and update differ");
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && in_stall |=> v_s3)
		else $error("stalled pipeline dropped a request");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Ray against a box-bounded plane: streams rays through the pipeline under
// random idling on both sides (off in one random phase), predicts each result
// with an exact fixed-point model and compares every field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import rbph_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        hit;
		logic        updated;
		logic [31:0] distance;
	} hit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic signed [15:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [31:0] best_distance = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit, updated;
	logic [31:0] distance_out;

	// local copy of the plane registers
	logic [47:0] normal_r, center_r, half_r;
	logic [15:0] offset_r;
	logic [19:0] eps_r;

	hit_result_t expected_hits[$];
	int mismatches = 0;
	int results_seen = 0;
	bit idle_on = 1'b1;

	ray_box_bounded_plane_hit dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic hit_result_t predict_hit(logic md, logic signed [15:0] sx,
			logic signed [15:0] sy, logic signed [15:0] sz, logic signed [15:0] dx,
			logic signed [15:0] dy, logic signed [15:0] dz, logic [31:0] best);
		hit_result_t r;
		longint s[3], d[3], n, c, h, p, lo, hi, d1, d2, plane_dist;
		logic [63:0] q, t;
		bit in_box;
		r.hit = 1'b0;
		r.updated = 1'b0;
		r.distance = best;
		s[0] = sx; s[1] = sy; s[2] = sz;
		d[0] = dx; d[1] = dy; d[2] = dz;
		d1 = 0;
		d2 = 0;
		for (int i = 0; i < 3; i++) begin
			n = $signed(normal_r[16*i +: 16]);
			d1 += n * d[i];
			d2 += n * s[i];
		end
		if (d1 > -longint'(eps_r) || d1 == 0)
			return r;
		plane_dist = d2 - longint'($signed(offset_r)) * 16384;
		if (plane_dist < 0)
			return r;
		q = (64'(plane_dist) * 64'd4194304) / 64'(-d1);
		t = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			c = $signed(center_r[16*i +: 16]);
			h = $signed(half_r[16*i +: 16]);
			p = s[i] * 4194304 + longint'(t) * d[i];
			lo = (c - h) * 4194304;
			hi = (c + h) * 4194304;
			if (p < lo || p > hi)
				in_box = 1'b0;
		end
		if (!md) begin
			if (in_box) begin
				r.hit = 1'b1;
				r.updated = 1'b1;
				r.distance = t[31:0];
			end
		end else begin
			r.hit = 1'b1;
			if (64'(best) > t && in_box) begin
				r.updated = 1'b1;
				r.distance = t[31:0];
			end
		end
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NORMAL:    normal_r = val;
			REG_OFFSET:    offset_r = val[15:0];
			REG_CENTER:    center_r = val;
			REG_HALF_SIZE: half_r = val;
			REG_EPSILON:   eps_r = val[19:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		int guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_hits.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
	endtask

	// valid stays high after an accept so the next request can follow at once
	task automatic send_ray(logic md, logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
			logic [15:0] dx, logic [15:0] dy, logic [15:0] dz, logic [31:0] best);
		while (idle_on && $urandom_range(99) < 30) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= md;
		start_x <= sx; start_y <= sy; start_z <= sz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		best_distance <= best;
		expected_hits.push_back(predict_hit(md, sx, sy, sz, dx, dy, dz, best));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// scoreboard
	always @(posedge clk) begin
		hit_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result hit=%0b upd=%0b dist=%h",
						hit, updated, distance_out);
			end else begin
				e = expected_hits.pop_front();
				if (hit !== e.hit || updated !== e.updated || distance_out !== e.distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0b upd=%0b dist=%h got %0b %0b %h",
							e.hit, e.updated, e.distance, hit, updated, distance_out);
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 30);
	end

	function automatic logic [15:0] rand_vec();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(32768) - 16384);
			3: return 16'($urandom_range(1024) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		return {z, y, x};
	endfunction

	// plane facing +z, ray from above heading down
	task automatic test_directed();
		write_reg(REG_NORMAL, pack3(16'h0, 16'h0, 16'h4000));
		write_reg(REG_OFFSET, 48'h0);
		write_reg(REG_CENTER, pack3(16'h0, 16'h0, 16'h0));
		write_reg(REG_HALF_SIZE, pack3(16'h0400, 16'h0400, 16'h0400));
		write_reg(REG_EPSILON, 48'd2684);
		send_ray(1'b0, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'hC000, 32'h0);
		send_ray(1'b1, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'hC000, 32'hFFFF_FFFF);
		send_ray(1'b1, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'hC000, 32'h1);
		// back-facing and parallel
		send_ray(1'b0, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'h4000, 32'h5);
		send_ray(1'b1, 16'h0, 16'h0, 16'h0200, 16'h4000, 16'h0, 16'h0, 32'h5);
		// behind start
		send_ray(1'b1, 16'h0, 16'h0, 16'hFE00, 16'h0, 16'h0, 16'hC000, 32'h5);
		// outside box, field extremes
		send_ray(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0, 16'h8000,
			32'hFFFF_FFFF);
		send_ray(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h0);
		// saturated t: tiny downward component
		send_ray(1'b1, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'hFFFF, 32'hFFFF_FFFF);
		drain();
		write_reg(REG_EPSILON, 48'd0);
		send_ray(1'b0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 32'h7);
		send_ray(1'b0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'hFFFF, 32'h7);
		drain();
		write_reg(REG_EPSILON, 48'hFFFFF);
		write_reg(REG_HALF_SIZE, pack3(16'hFF00, 16'h0400, 16'h0400));
		send_ray(1'b0, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'hC000, 32'h0);
		send_ray(1'b1, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0, 16'h8000, 32'h9);
		drain();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			idle_on = (phase != 3);
			write_reg(REG_NORMAL, (phase == 5) ? 48'hFFFF_FFFF_FFFF :
				pack3(rand_vec(), rand_vec(), rand_vec()));
			write_reg(REG_OFFSET, (phase == 4) ? 48'h8000 :
				48'(16'($urandom_range(1024) - 512)));
			write_reg(REG_CENTER, (phase == 4) ? 48'h7FFF_7FFF_7FFF :
				pack3(16'($urandom), 16'($urandom), 16'($urandom)) & 48'h0FFF_0FFF_0FFF);
			write_reg(REG_HALF_SIZE, (phase == 5) ? 48'h7FFF_7FFF_7FFF :
				pack3(16'($urandom_range(8000)), 16'($urandom_range(8000)),
					16'($urandom_range(8000))));
			write_reg(REG_EPSILON, (phase == 2) ? 48'hFFFFF : 48'($urandom_range(4000)));
			for (int k = 0; k < 205; k++) begin
				logic [15:0] dx, dy, dz;
				logic [47:0] nn;
				dx = rand_vec(); dy = rand_vec(); dz = rand_vec();
				// mostly point the ray against the normal so it faces the plane
				if ($urandom_range(3) != 0) begin
					nn = normal_r;
					dx = -nn[15:0] ^ 16'($urandom_range(255));
					dy = -nn[31:16] ^ 16'($urandom_range(255));
					dz = -nn[47:32] ^ 16'($urandom_range(255));
				end
				send_ray(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
					16'($urandom), dx, dy, dz,
					($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
			end
			drain();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		normal_r = '0; center_r = '0; half_r = '0; offset_r = '0;
		eps_r = EPS_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		if (mismatches == 0 && expected_hits.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
